// ----- rtl/mfd_pkg.sv -----
// Shared types and constants of the message frame deframer.
`default_nettype none
package mfd_pkg;

  localparam int unsigned HeaderBytes   = 16;
  localparam logic [31:0] ResetMagic    = 32'h5450_0400;
  localparam logic [7:0]  ResetHighest  = 8'd71;
  localparam int unsigned DefQueueDepth = 4;
  localparam int unsigned AddrWidth     = 3;

  // header byte positions
  localparam logic [3:0] HcMagicLast = 4'd3;
  localparam logic [3:0] HcSeqFirst  = 4'd4;
  localparam logic [3:0] HcTypeFirst = 4'd8;
  localparam logic [3:0] HcTypeLast  = 4'd11;
  localparam logic [3:0] HcLenFirst  = 4'd12;
  localparam logic [3:0] HcFinal     = 4'(HeaderBytes - 1);

  // register indexes on the configuration port
  localparam logic RegMagic   = 1'b0;
  localparam logic RegHighest = 1'b1;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  localparam logic ERR_MAGIC = 1'b0;
  localparam logic ERR_TYPE  = 1'b1;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq_number;
    logic [7:0]  msg_type;
    logic [31:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;
    logic        error_code;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/mfd_front.sv -----
// Front end: header parser and payload counter, one byte per beat.
`default_nettype none
module mfd_front
  import mfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic [31:0] expected_magic,
  input  wire logic [7:0]  highest_type,
  input  wire logic        q_full,
  output logic             q_push,
  output res_t             q_rec
);

  logic        phase;
  logic [3:0]  header_count;
  logic        magic_ok;
  logic [31:0] seq_shift;
  logic [7:0]  type_lo;
  logic        type_hi;
  logic [31:0] len_shift;
  logic [31:0] bytes_left;

  logic        phase_next;
  logic [3:0]  header_count_next;
  logic        magic_ok_next;
  logic [31:0] bytes_left_next;

  logic        take;
  logic [7:0]  want;
  logic        mok;
  logic [31:0] len_full;
  logic        type_bad;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    case (header_count[1:0])
      2'd0:    want = expected_magic[31:24];
      2'd1:    want = expected_magic[23:16];
      2'd2:    want = expected_magic[15:8];
      default: want = expected_magic[7:0];
    endcase
  end

  assign mok      = ((header_count == '0) || magic_ok) && (in_byte == want);
  assign len_full = {len_shift[23:0], in_byte};
  assign type_bad = type_hi || (type_lo > highest_type);

  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    magic_ok_next     = magic_ok;
    bytes_left_next   = bytes_left;
    q_push            = 1'b0;
    q_rec             = '{kind: KIND_HEADER, seq_number: seq_shift, msg_type: type_lo,
                          payload_len: len_shift, data_byte: 8'd0, last: 1'b0,
                          error_code: 1'b0};
    if (take) begin
      if (phase) begin
        q_push          = 1'b1;
        q_rec.kind      = KIND_DATA;
        q_rec.data_byte = in_byte;
        q_rec.last      = (bytes_left <= 32'd1);
        bytes_left_next = bytes_left - 32'd1;
        if (bytes_left <= 32'd1) begin
          phase_next        = 1'b0;
          header_count_next = '0;
          magic_ok_next     = 1'b1;
        end
      end else if (header_count <= HcMagicLast) begin
        magic_ok_next     = mok;
        header_count_next = header_count + 4'd1;
        if (header_count == HcMagicLast && !mok) begin
          q_push            = 1'b1;
          q_rec             = '{kind: KIND_ERROR, seq_number: 32'd0, msg_type: 8'd0,
                                payload_len: 32'd0, data_byte: 8'd0, last: 1'b0,
                                error_code: ERR_MAGIC};
          header_count_next = '0;
          magic_ok_next     = 1'b1;
        end
      end else if (header_count != HcFinal) begin
        header_count_next = header_count + 4'd1;
      end else begin
        q_push            = 1'b1;
        header_count_next = '0;
        q_rec.payload_len = len_full;
        if (type_bad) begin
          q_rec.kind       = KIND_ERROR;
          q_rec.error_code = ERR_TYPE;
          magic_ok_next    = 1'b1;
        end else if (len_full == 32'd0) begin
          q_rec.last    = 1'b1;
          magic_ok_next = 1'b1;
        end else begin
          phase_next      = 1'b1;
          bytes_left_next = len_full;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      header_count <= '0;
      magic_ok     <= 1'b1;
      bytes_left   <= '0;
    end else begin
      phase        <= phase_next;
      header_count <= header_count_next;
      magic_ok     <= magic_ok_next;
      bytes_left   <= bytes_left_next;
    end
  end

  // header field shift registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_shift <= '0;
      type_lo   <= '0;
      type_hi   <= 1'b0;
      len_shift <= '0;
    end else if (take && !phase) begin
      if (header_count >= HcSeqFirst && header_count < HcTypeFirst) begin
        seq_shift <= {seq_shift[23:0], in_byte};
      end else if (header_count >= HcTypeFirst && header_count < HcLenFirst) begin
        type_lo <= in_byte;
        // upper 24 bits of the type only need an any-nonzero flag
        if (header_count == HcTypeFirst) begin
          type_hi <= (in_byte != 8'd0);
        end else if (header_count != HcTypeLast) begin
          type_hi <= type_hi || (in_byte != 8'd0);
        end
      end else if (header_count >= HcLenFirst) begin
        len_shift <= len_full;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mfd_queue.sv -----
// Short result queue between the parser and the output stage.
`default_nettype none
module mfd_queue
  import mfd_pkg::*;
#(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  res_t      push_rec,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output res_t      head_rec
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_rec   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mfd_back.sv -----
// Back end: output register that hands result beats to the consumer.
`default_nettype none
module mfd_back
  import mfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  res_t      head_rec,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_rec
);

  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= head_rec;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/message_frame_deframer_core.sv -----
// Top level of the message frame deframer: config registers, parser, queue, output stage.
`default_nettype none
// Takes one stream byte per clock and emits at most one result beat per byte:
// a header beat after the 16th header byte, one data beat per payload byte, or
// an error beat for a bad magic (on the 4th byte) or an unknown type (on the
// 16th byte). Each result beat is written from the parser into the queue and then
// passes through the output register to the consumer. Sustained rate is
// one byte per clock; the parser stalls its input only when the QueueDepth-entry
// result queue is full, which happens only while out_stall holds results back.
// Write expected_magic (address 0) and highest_type (address 4) while idle.
module message_frame_deframer_core
  import mfd_pkg::*;
#(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                kind,
  output logic [31:0]               seq_number,
  output logic [7:0]                msg_type,
  output logic [31:0]               payload_len,
  output logic [7:0]                data_byte,
  output logic                      last,
  output logic                      error_code,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [31:0] expected_magic;
  logic [7:0]  highest_type;
  logic        cfg_wr;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  res_t q_rec;
  res_t q_head;
  res_t out_rec;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic <= ResetMagic;
      highest_type   <= ResetHighest;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegMagic:   expected_magic <= pwdata;
        RegHighest: highest_type   <= pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegMagic:   prdata = expected_magic;
      RegHighest: prdata = {24'd0, highest_type};
      default:    prdata = '0;
    endcase
  end

  mfd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .expected_magic (expected_magic),
    .highest_type   (highest_type),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_rec          (q_rec)
  );

  mfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (q_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_rec   (q_head)
  );

  mfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_rec   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rec    (out_rec)
  );

  assign kind        = out_rec.kind;
  assign seq_number  = out_rec.seq_number;
  assign msg_type    = out_rec.msg_type;
  assign payload_len = out_rec.payload_len;
  assign data_byte   = out_rec.data_byte;
  assign last        = out_rec.last;
  assign error_code  = out_rec.error_code;

endmodule
`default_nettype wire

// ----- rtl/mfd_checker.sv -----
// Port-level checks on the deframer top level, bound in below.
`default_nettype none
module mfd_checker
  import mfd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  kind,
  input wire logic [31:0] seq_number,
  input wire logic [7:0]  msg_type,
  input wire logic [31:0] payload_len,
  input wire logic [7:0]  data_byte,
  input wire logic        last,
  input wire logic        error_code
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(seq_number)
      && $stable(msg_type) && $stable(payload_len) && $stable(data_byte)
      && $stable(last) && $stable(error_code))
    else $error("result beat changed while stalled");

  // only data beats carry a byte
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> data_byte == 8'd0)
    else $error("data_byte set on non-data beat");

  // bad magic reports no header fields
  a_magic_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERROR && error_code == ERR_MAGIC
      |-> seq_number == 32'd0 && msg_type == 8'd0 && payload_len == 32'd0 && !last)
    else $error("bad magic beat carries fields");

  // an empty frame ends on its header
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_HEADER |-> last == (payload_len == 32'd0))
    else $error("header last flag wrong");

endmodule

bind message_frame_deframer_core mfd_checker u_mfd_checker (.*);
`default_nettype wire
